/* src/dld_pkg.sv */
// Shared types, constants and operation codes for the deadlock detector.
`default_nettype none
package dld_pkg;
    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;
    localparam int AMOUNT_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        OP_LOAD_AVAIL = 2'd0,
        OP_LOAD_ALLOC = 2'd1,
        OP_LOAD_REQ   = 2'd2,
        OP_CHECK      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_PROCESS_COUNT  = 2'd0,
        CFG_RESOURCE_COUNT = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  process_index;
        logic [2:0]  resource_index;
        logic [15:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [3:0] process_id;
        logic       blocked;
        logic       deadlock_found;
        logic       last;
    } out_item_t;

    // Control from the sequencer to the resource cells.
    typedef struct packed {
        logic load_avail;
        logic compare_start;
        logic release_en;
    } cell_ctrl_t;
endpackage
`default_nettype wire

/* src/dld_cell.sv */
// One resource cell: holds one available count, compares and releases.
`default_nettype none
module dld_cell #(
    parameter int AMOUNT_BITS = dld_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dld_pkg::cell_ctrl_t    ctrl,
    input  wire logic                   active,
    input  wire logic [AMOUNT_BITS-1:0] load_value,
    input  wire logic [AMOUNT_BITS-1:0] req_value,
    input  wire logic [AMOUNT_BITS-1:0] alloc_value,
    input  wire logic                   fit_in,
    output logic                        fit_out
);
    logic [AMOUNT_BITS-1:0] avail_reg, avail_next;
    logic [AMOUNT_BITS:0]   sum;
    logic                   fit_reg, fit_next;

    assign sum = {1'b0, avail_reg} + {1'b0, alloc_value};

    always_comb
    begin
        avail_next = avail_reg;
        if (ctrl.load_avail)
        begin
            avail_next = load_value;
        end
        else if (ctrl.release_en && active)
        begin
            avail_next = sum[AMOUNT_BITS] ? {AMOUNT_BITS{1'b1}} : sum[AMOUNT_BITS-1:0];
        end
    end

    // The fit flag ripples from cell to cell, one stage per clock.
    always_comb
    begin
        fit_next = fit_in && (!active || (avail_reg >= req_value));
    end

    always_ff @(posedge clk)
    begin
        avail_reg <= avail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg <= 1'b0;
        end
        else
        begin
            fit_reg <= fit_next;
        end
    end

    assign fit_out = fit_reg;
endmodule
`default_nettype wire

/* src/dld_ctrl.sv */
// Check sequencer: walks processes, drives the cell chain, emits results.
`default_nettype none
module dld_ctrl #(
    parameter int MAX_PROCESSES = dld_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = dld_pkg::MAX_RESOURCES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [$clog2(MAX_PROCESSES+1)-1:0] np,
    input  wire logic                             chain_fit,
    input  wire logic                             out_stall,
    output dld_pkg::state_t                       state,
    output logic [$clog2(MAX_PROCESSES)-1:0]      proc,
    output dld_pkg::cell_ctrl_t                   ctrl,
    output logic                                  out_valid,
    output dld_pkg::out_item_t                    out_item
);
    localparam int PW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_RESOURCES + 1);

    dld_pkg::state_t state_reg, state_next;
    logic [PW-1:0] proc_reg, proc_next;
    logic [CW-1:0] wait_reg, wait_next;
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic progress_reg, progress_next;
    logic last_proc;
    logic fits;

    assign last_proc = ({1'b0, proc_reg} == ({1'b0, np} - 1'b1));
    assign fits = chain_fit && !fin_reg[proc_reg];

    always_comb
    begin
        state_next    = state_reg;
        proc_next     = proc_reg;
        wait_next     = wait_reg;
        fin_next      = fin_reg;
        progress_next = progress_reg;
        case (state_reg)
            dld_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    fin_next      = '0;
                    proc_next     = '0;
                    progress_next = 1'b0;
                    state_next    = dld_pkg::ST_FETCH;
                end
            end
            dld_pkg::ST_FETCH:
            begin
                // The memory read is registered, then the chain ripples.
                wait_next  = MAX_RESOURCES[CW-1:0];
                state_next = dld_pkg::ST_EVAL;
            end
            dld_pkg::ST_EVAL:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else
                begin
                    if (fits)
                    begin
                        fin_next[proc_reg] = 1'b1;
                    end
                    if (last_proc)
                    begin
                        proc_next = '0;
                        if (fits || progress_reg)
                        begin
                            progress_next = 1'b0;
                            state_next    = dld_pkg::ST_FETCH;
                        end
                        else
                        begin
                            state_next = dld_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        proc_next     = proc_reg + 1'b1;
                        progress_next = progress_reg || fits;
                        state_next    = dld_pkg::ST_FETCH;
                    end
                end
            end
            dld_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (last_proc)
                    begin
                        proc_next  = '0;
                        state_next = dld_pkg::ST_IDLE;
                    end
                    else
                    begin
                        proc_next = proc_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = dld_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.load_avail    = 1'b0;
        ctrl.compare_start = (state_reg == dld_pkg::ST_FETCH);
        ctrl.release_en    = (state_reg == dld_pkg::ST_EVAL) && (wait_reg == '0) && fits;
        out_valid          = (state_reg == dld_pkg::ST_EMIT);
        out_item.process_id     = 4'(proc_reg);
        out_item.blocked        = !fin_reg[proc_reg];
        out_item.deadlock_found = 1'b0;
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            if (i < int'(np) && !fin_reg[i])
            begin
                out_item.deadlock_found = 1'b1;
            end
        end
        out_item.last = last_proc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dld_pkg::ST_IDLE;
            proc_reg     <= '0;
            wait_reg     <= '0;
            fin_reg      <= '0;
            progress_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            proc_reg     <= proc_next;
            wait_reg     <= wait_next;
            fin_reg      <= fin_next;
            progress_reg <= progress_next;
        end
    end

    assign state = state_reg;
    assign proc  = proc_reg;

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_proc |=> state_reg == dld_pkg::ST_IDLE)
        else $error("emit did not return to idle");
    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.release_en |=> fin_reg[$past(proc_reg)])
        else $error("released process not marked finished");
    a_eval_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dld_pkg::ST_FETCH |=> state_reg == dld_pkg::ST_EVAL)
        else $error("fetch not followed by eval");
endmodule
`default_nettype wire

/* src/deadlock_detection.sv */
// Deadlock detector top level: stores, configuration and resource cell chain.
// Usage:
//   Input channel (in_valid/in_stall, payload in_item) carries load and check
//   transfers. Loads of the available vector and of the allocation and
//   request matrices are taken one per cycle while idle and produce no result.
//   A check transfer starts a sequence of passes over the processes in use.
//   Each process step first reads its rows from the matrix memories into
//   registers, then the fit flag ripples down the chain of one cell per
//   resource. A check makes passes over the processes, at most
//   process_count + 1 of them, followed by one result per process.
//   Output channel (out_valid/out_stall, payload out_item) presents one
//   result per cycle; a stall holds the current result until it transfers.
//   No input is accepted while a check is running or results remain.
//   Reset returns the sequencer to idle and the counts to 16 and 8; store
//   contents are undefined until loaded.
`default_nettype none
module deadlock_detection #(
    parameter int MAX_PROCESSES = dld_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = dld_pkg::MAX_RESOURCES_DEF,
    parameter int AMOUNT_BITS   = dld_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dld_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dld_pkg::out_item_t      out_item,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [4:0]         cfg_data
);
    localparam int PW = $clog2(MAX_PROCESSES);
    localparam int RW = $clog2(MAX_RESOURCES);
    localparam int NPW = $clog2(MAX_PROCESSES + 1);
    localparam int NRW = $clog2(MAX_RESOURCES + 1);

    logic [4:0] pcount_reg;
    logic [3:0] rcount_reg;
    logic [NPW-1:0] np;
    logic [NRW-1:0] nres;
    dld_pkg::state_t state;
    logic [PW-1:0] proc;
    dld_pkg::cell_ctrl_t seq_ctrl;
    logic accept;
    logic chain_fit;
    logic compare_reg;
    logic [AMOUNT_BITS-1:0] amt;
    logic [AMOUNT_BITS*MAX_RESOURCES-1:0] alloc_mem [MAX_PROCESSES];
    logic [AMOUNT_BITS*MAX_RESOURCES-1:0] req_mem [MAX_PROCESSES];
    logic [AMOUNT_BITS*MAX_RESOURCES-1:0] alloc_row_reg, req_row_reg;
    logic [MAX_RESOURCES:0] fit_chain;
    logic pi_ok, ri_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 5'd16;
            rcount_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                1'(dld_pkg::CFG_PROCESS_COUNT):  pcount_reg <= cfg_data;
                1'(dld_pkg::CFG_RESOURCE_COUNT): rcount_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pcount_reg == '0)
            np = NPW'(1);
        else if (32'(pcount_reg) > MAX_PROCESSES)
            np = NPW'(MAX_PROCESSES);
        else
            np = NPW'(pcount_reg);
        if (rcount_reg == '0)
            nres = NRW'(1);
        else if (32'(rcount_reg) > MAX_RESOURCES)
            nres = NRW'(MAX_RESOURCES);
        else
            nres = NRW'(rcount_reg);
    end

    assign in_stall = (state != dld_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign amt      = AMOUNT_BITS'(in_item.amount);
    assign pi_ok    = 32'(in_item.process_index) < MAX_PROCESSES;
    assign ri_ok    = 32'(in_item.resource_index) < MAX_RESOURCES;

    always_ff @(posedge clk)
    begin
        if (accept && pi_ok && ri_ok)
        begin
            if (in_item.operation == dld_pkg::OP_LOAD_ALLOC)
                alloc_mem[PW'(in_item.process_index)]
                    [RW'(in_item.resource_index)*AMOUNT_BITS +: AMOUNT_BITS] <= amt;
            if (in_item.operation == dld_pkg::OP_LOAD_REQ)
                req_mem[PW'(in_item.process_index)]
                    [RW'(in_item.resource_index)*AMOUNT_BITS +: AMOUNT_BITS] <= amt;
        end
        alloc_row_reg <= alloc_mem[proc];
        req_row_reg   <= req_mem[proc];
    end

    dld_ctrl #(
        .MAX_PROCESSES(MAX_PROCESSES),
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && in_item.operation == dld_pkg::OP_CHECK),
        .np        (np),
        .chain_fit (chain_fit),
        .out_stall (out_stall),
        .state     (state),
        .proc      (proc),
        .ctrl      (seq_ctrl),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // The chain starts in the cycle after the fetch, once the row registers hold
    // the current process.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg <= 1'b0;
        end
        else
        begin
            compare_reg <= seq_ctrl.compare_start;
        end
    end

    assign fit_chain[0] = compare_reg;
    assign chain_fit = fit_chain[MAX_RESOURCES];

    genvar g;
    generate
        for (g = 0; g < MAX_RESOURCES; g++)
        begin : g_cell
            dld_pkg::cell_ctrl_t cc;
            always_comb
            begin
                cc = seq_ctrl;
                cc.load_avail = accept && in_item.operation == dld_pkg::OP_LOAD_AVAIL
                                && ri_ok && (32'(in_item.resource_index) == g);
            end
            dld_cell #(.AMOUNT_BITS(AMOUNT_BITS)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cc),
                .active      (g < int'(nres)),
                .load_value  (amt),
                .req_value   (req_row_reg[g*AMOUNT_BITS +: AMOUNT_BITS]),
                .alloc_value (alloc_row_reg[g*AMOUNT_BITS +: AMOUNT_BITS]),
                .fit_in      (fit_chain[g]),
                .fit_out     (fit_chain[g+1])
            );
        end
    endgenerate

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while results pending");
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state == dld_pkg::ST_IDLE |-> !out_valid)
        else $error("result while idle");
    a_check_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.operation == dld_pkg::OP_CHECK |=> state == dld_pkg::ST_FETCH)
        else $error("check did not start");
endmodule
`default_nettype wire
